// ----- rtl/core/sitda_pkg.sv -----
// Package for the signed integer to decimal ASCII converter.
// Character codes and shared sizing constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

  localparam int DEF_VALUE_BITS = 32;

  // input bits folded into the BCD register per conversion cycle
  localparam int BITS_PER_STEP = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

endpackage : sitda_pkg

`default_nettype wire

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII converter, top level.
// Iterative shift-add-3 (double dabble) unit under a small sequencer.
// Depends on sitda_pkg.
//
// Sequence: word accepted in idle, then the dabble steps of 4 input bits each, then the
// leading-digit search, then one character per cycle into the output register while
// out_ready allows; a stalled output holds the emit state. A new word is taken only once
// the last character of the previous one is loaded into the output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sitda_pkg::DEF_VALUE_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [7:0]                   out_ascii_char,
  output      logic                         out_last_char
);
  import sitda_pkg::*;

  // magnitude padded up to whole dabble steps
  localparam int STEPS   = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int MAG_W   = STEPS * BITS_PER_STEP;
  // decimal digits of 2^VALUE_BITS, upper bound via 1233/4096 ~ log10(2)
  localparam int NDIG    = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W   = NDIG * 4;
  localparam int IDX_W   = $clog2(NDIG);
  localparam int STEP_CW = $clog2(STEPS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STEP_CW-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               neg_r, neg_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [7:0]         char_r, char_nxt;
  logic               last_r, last_nxt;

  logic [VALUE_BITS-1:0] mag_c;
  logic [BCD_W-1:0]      dabble_c;
  logic [IDX_W-1:0]      top_c;
  logic [3:0]            digit_c;
  logic                  load_ok;

  assign mag_c = in_value[VALUE_BITS-1] ? (~$unsigned(in_value) + 1'b1) : $unsigned(in_value);

  // shared unit: four shift-add-3 steps, MSB of the nibble first
  always_comb begin
    logic [BCD_W-1:0] tmp;
    logic [3:0]       nib;
    tmp = bcd_r;
    nib = mag_r[MAG_W-1 -: BITS_PER_STEP];
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (tmp[d*4 +: 4] >= 4'd5) begin
          tmp[d*4 +: 4] = tmp[d*4 +: 4] + 4'd3;
        end
      end
      tmp = {tmp[BCD_W-2:0], nib[BITS_PER_STEP-1-s]};
    end
    dabble_c = tmp;
  end

  // highest nonzero digit; zero leaves the single digit at index 0
  always_comb begin
    top_c = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        top_c = IDX_W'(d);
      end
    end
  end

  assign digit_c = bcd_r[idx_r*4 +: 4];
  assign load_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    char_nxt      = char_r;
    last_nxt      = last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_value[VALUE_BITS-1];
          mag_nxt   = MAG_W'(mag_c);
          bcd_nxt   = '0;
          step_nxt  = STEP_CW'(STEPS - 1);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = dabble_c;
        mag_nxt = mag_r << BITS_PER_STEP;
        if (step_r == '0) begin
          state_nxt = S_FIND;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_FIND: begin
        idx_nxt   = top_c;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            char_nxt = CHAR_MINUS;
            last_nxt = 1'b0;
            neg_nxt  = 1'b0;
          end else begin
            char_nxt = CHAR_ZERO | {4'b0000, digit_c};
            last_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ascii_char = char_r;
  assign out_last_char  = last_r;

endmodule : signed_int_to_decimal_ascii

`default_nettype wire

// ----- rtl/core/sitda_checker.sv -----
// Port-level checker for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sitda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitda_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_ascii_char,
  input wire logic       out_last_char
);
  import sitda_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ascii_char) && $stable(out_last_char))
    else $error("output word changed while stalled");

  // one number at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while converting");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii_char == CHAR_MINUS) ||
                  (out_ascii_char >= CHAR_ZERO && out_ascii_char <= CHAR_NINE))
    else $error("character outside minus and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ascii_char == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign flagged as last");

  // an accepted minus sign is never followed by a second minus sign
  a_digit_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_ascii_char == CHAR_MINUS
      |=> !out_valid || out_ascii_char != CHAR_MINUS)
    else $error("two minus signs in a row");

endmodule : sitda_checker

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_ascii_char(out_ascii_char),
  .out_last_char (out_last_char)
);

`default_nettype wire
